// File: design/bb3_pkg.sv
// shared types, register indexes and the reciprocal table for the box blur
package bb3_pkg;

	localparam int RECIP_SHIFT = 21;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1
	} bb3_reg_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic sum;
		logic mul;
		logic load_out;
	} bb3_cmd_t;

	typedef struct packed {
		logic frame_open;
		logic emit;
		logic out_free;
	} bb3_sts_t;

	// ceil(2^21 / (2*cnt)), exact for numerators below 4600
	function automatic logic [20:0] recip(input logic [3:0] cnt);
		logic [20:0] r;
		case (cnt)
			4'd1: r = 21'd1048576;
			4'd2: r = 21'd524288;
			4'd3: r = 21'd349526;
			4'd4: r = 21'd262144;
			4'd5: r = 21'd209716;
			4'd6: r = 21'd174763;
			4'd7: r = 21'd149797;
			4'd8: r = 21'd131072;
			4'd9: r = 21'd116509;
			default: r = 21'd1048576;
		endcase
		return r;
	endfunction

endpackage

// File: design/box_blur_3x3_rgb.sv
// top level of the streaming 3x3 rgb box blur
// a request with a result passes the read, sum, scale and load states before it shows on
//   the output, the load waiting while an untaken result is held; one with no result ends
//   after the sum; new requests are taken only in idle; a flush in an open frame is dropped
// reset: clears counters, window and output valid; width 640, height 480
// line stores have no clearing pass and are read only where written in the frame
module box_blur_3x3_rgb
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        end_of_row,
	output logic        end_of_frame
);

	bb3_cmd_t cmd;
	bb3_sts_t sts;

	bb3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bb3_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.in_red       (in_red),
		.in_green     (in_green),
		.in_blue      (in_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule

// File: design/bb3_ctrl.sv
// sequencer for one request: read line stores, sum window, then scale and hand over a result if one is due
module bb3_ctrl
	import bb3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     opcode,
	output logic     in_ready,
	input  bb3_sts_t sts,
	output bb3_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		// a flush while the frame is still open is dropped on the spot
		cmd.capture  = accept && !(opcode && sts.frame_open);
		cmd.read     = (state_q == ST_READ);
		cmd.sum      = (state_q == ST_SUM);
		cmd.mul      = (state_q == ST_MUL);
		cmd.load_out = (state_q == ST_OUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= sts.emit ? ST_MUL : ST_IDLE;
				end
				ST_MUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/bb3_datapath.sv
// line stores, window, position counters, averaging and output register
module bb3_datapath
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bb3_cmd_t    cmd,
	output bb3_sts_t    sts,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        opcode,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        end_of_row,
	output logic        end_of_frame
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = AW + 1;
	localparam int OW = EW + 16;

	logic [10:0]   width_q;
	logic [15:0]   height_q;
	logic [13:0]   width_ext;
	logic [EW-1:0] eff_w;
	logic [15:0]   eff_h;
	logic [OW-1:0] last_idx_q;

	logic [AW-1:0] col_q;
	logic [16:0]   row_q;
	logic [OW-1:0] out_idx_q;

	logic [23:0] older_mem [MAX_WIDTH];
	logic [23:0] newer_mem [MAX_WIDTH];
	logic [23:0] older_rd_q;
	logic [23:0] newer_rd_q;
	logic        pix_q;
	logic [23:0] pix_data_q;

	// window columns: [r][0] is the left neighbor, [r][1] the center
	logic [23:0] win_q [3][2];
	logic [23:0] col_in [3];

	logic [EW-1:0] col_next;
	logic          wrap;
	logic          emit;
	logic [EW-1:0] c_val;
	logic [16:0]   r_val;
	logic          row_inc [3];
	logic          left_inc;
	logic          right_inc;
	logic [1:0]    n_rows;
	logic [1:0]    n_cols;
	logic [3:0]    cnt;
	logic [11:0]   sum [3];
	logic          eor;
	logic          eof;
	logic          cfg_hit;

	logic [11:0] sum_s1 [3];
	logic [3:0]  cnt_s1;
	logic        eor_s1;
	logic        eof_s1;
	logic [7:0]  q_s2 [3];
	logic        eor_s2;
	logic        eof_s2;

	logic [7:0] out_red_q;
	logic [7:0] out_green_q;
	logic [7:0] out_blue_q;
	logic       eor_q;
	logic       eof_q;
	logic       out_valid_q;

	assign width_ext = 14'(width_q);
	always_comb begin
		if (width_ext == '0) eff_w = EW'(1);
		else if (width_ext > 14'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
		else eff_w = EW'(width_ext);
	end
	assign eff_h = (height_q == '0) ? 16'd1 : height_q;

	assign cfg_hit = cfg_we &&
		((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

	assign col_next = EW'(col_q) + EW'(1);
	assign wrap     = col_next >= eff_w;
	assign emit     = (row_q >= 17'd2) || ((row_q == 17'd1) && (col_q != '0));

	// at the first column the pending pixel is the last one of two rows back
	assign c_val = (col_q == '0) ? (eff_w - EW'(1)) : (EW'(col_q) - EW'(1));
	assign r_val = (col_q == '0) ? (row_q - 17'd2) : (row_q - 17'd1);

	assign row_inc[0] = (r_val != '0);
	assign row_inc[1] = 1'b1;
	assign row_inc[2] = (r_val + 17'd1) < {1'b0, eff_h};
	assign left_inc   = (c_val != '0);
	assign right_inc  = (c_val + EW'(1)) < eff_w;
	assign n_rows = 2'd1 + 2'(row_inc[0]) + 2'(row_inc[2]);
	assign n_cols = 2'd1 + 2'(left_inc) + 2'(right_inc);
	assign cnt    = 4'(n_rows) * 4'(n_cols);
	assign eor    = (c_val + EW'(1)) == eff_w;
	assign eof    = out_idx_q == last_idx_q;

	assign col_in[0] = ((row_q >= 17'd2) && (row_q <= {1'b0, eff_h})) ? older_rd_q : '0;
	assign col_in[1] = ((row_q >= 17'd1) && (row_q <= {1'b0, eff_h})) ? newer_rd_q : '0;
	assign col_in[2] = pix_q ? pix_data_q : '0;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = '0;
			for (int r = 0; r < 3; r++) begin
				if (row_inc[r]) begin
					sum[k] = sum[k] + 12'(win_q[r][1][8*(2-k) +: 8]);
					if (left_inc) sum[k] = sum[k] + 12'(win_q[r][0][8*(2-k) +: 8]);
					if (right_inc) sum[k] = sum[k] + 12'(col_in[r][8*(2-k) +: 8]);
				end
			end
		end
	end

	assign sts.frame_open = row_q < {1'b0, eff_h};
	assign sts.emit       = emit;
	assign sts.out_free   = !out_valid_q || out_ready;

	// control state and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 11'd640;
			height_q   <= 16'd480;
			last_idx_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			out_idx_q  <= '0;
			win_q      <= '{default: '0};
			out_valid_q <= 1'b0;
		end else begin
			last_idx_q <= OW'(eff_w) * OW'(eff_h) - OW'(1);
			if (cfg_hit) begin
				if (cfg_index == REG_WIDTH) width_q <= cfg_data[10:0];
				else height_q <= cfg_data;
				col_q     <= '0;
				row_q     <= '0;
				out_idx_q <= '0;
				win_q     <= '{default: '0};
			end else if (cmd.sum) begin
				if (emit && eof) begin
					col_q     <= '0;
					row_q     <= '0;
					out_idx_q <= '0;
					win_q     <= '{default: '0};
				end else begin
					if (wrap) begin
						col_q <= '0;
						row_q <= row_q + 17'd1;
					end else begin
						col_q <= col_next[AW-1:0];
					end
					if (emit) out_idx_q <= out_idx_q + OW'(1);
					for (int r = 0; r < 3; r++) begin
						win_q[r][0] <= win_q[r][1];
						win_q[r][1] <= col_in[r];
					end
				end
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// line stores and arithmetic stages
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q      <= !opcode && sts.frame_open;
			pix_data_q <= {in_red, in_green, in_blue};
		end
		if (cmd.read) begin
			older_rd_q <= older_mem[col_q];
			newer_rd_q <= newer_mem[col_q];
		end
		if (cmd.sum && pix_q) begin
			older_mem[col_q] <= newer_rd_q;
			newer_mem[col_q] <= pix_data_q;
		end
		if (cmd.sum) begin
			sum_s1 <= sum;
			cnt_s1 <= cnt;
			eor_s1 <= eor;
			eof_s1 <= eof;
		end
		if (cmd.mul) begin
			for (int k = 0; k < 3; k++) begin
				q_s2[k] <= 8'((34'({sum_s1[k], 1'b0} + 13'(cnt_s1)) * 34'(recip(cnt_s1)))
					>> RECIP_SHIFT);
			end
			eor_s2 <= eor_s1;
			eof_s2 <= eof_s1;
		end
		if (cmd.load_out) begin
			out_red_q   <= q_s2[0];
			out_green_q <= q_s2[1];
			out_blue_q  <= q_s2[2];
			eor_q       <= eor_s2;
			eof_q       <= eof_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_red      = out_red_q;
	assign out_green    = out_green_q;
	assign out_blue     = out_blue_q;
	assign end_of_row   = eor_q;
	assign end_of_frame = eof_q;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(col_q) < eff_w)
		else $error("column counter past row width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ({1'b0, eff_h} + 17'd1))
		else $error("row counter past drain row");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending one");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sum && emit && eof && !cfg_hit) |=> (out_idx_q == '0 && row_q == '0))
		else $error("frame did not restart after last pixel");

endmodule
